FILE: src/fcc16_pkg.sv
// Shared constants, status codes and the CRC byte step for the CRC-16 frame checker.
package fcc16_pkg;

  // Header layout: byte offsets within the frame.
  localparam int HDR_MAGIC_LO   = 0;
  localparam int HDR_MAGIC_HI   = 1;
  localparam int HDR_VER_TYPE   = 2;
  localparam int HDR_FLAGS      = 3;
  localparam int HDR_TTL        = 4;
  localparam int HDR_SOURCE     = 5;
  localparam int HDR_DEST       = 13;
  localparam int HDR_SEQUENCE   = 21;
  localparam int HDR_LENGTH_LO  = 25;
  localparam int HDR_LENGTH_HI  = 26;
  localparam int HDR_LEN        = 27;
  localparam int CRC_BYTES      = 2;
  localparam int MIN_FRAME      = HDR_LEN + CRC_BYTES;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_MAGIC   = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_TYPE    = 3'd4;
  localparam logic [2:0] ST_LENGTH  = 3'd5;
  localparam logic [2:0] ST_CRC     = 3'd6;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VERSION     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGHEST_TYPE = 2'd2;

  // Result beat: 203 bits of fields, padded to 26 bytes.
  localparam int RES_BITS = 203;
  localparam int M_DATA_W = 208;

  // One byte through the CRC, most significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/frame_checker_crc16_core.sv
// Frame checker: header capture, CRC-16/CCITT-FALSE and end-of-frame status report.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-----------------------------------------------
//  s_*      | in  | s_tvalid/s_tready | s_tdata: data_byte[7:0]; s_tlast: last_byte
//  m_*      | out | m_tvalid/m_tready | m_tdata: status, version, frame_type, flag_bits,
//           |     |                   |   hop_limit, source, destination, sequence_res,
//           |     |                   |   payload_length, zero pad
//  cfg_*    | in  | cfg_we            | cfg_index selects register, cfg_data its value
//
// Every accepted beat is handled in the cycle it arrives: the header capture, the
// eight-bit CRC step and, on the final beat, the checks all sit between the frame
// state and result registers, so one beat a cycle is sustained unless input stalls.
// A result appears on m_* the cycle after the final beat of its frame.
// The result register acts as the output stage: s_tready stays high while it is
// empty or being emptied, so only a result that is held by m_tready stalls input.
// rst is synchronous and active high; it clears the frame state, the result valid
// flag and the configuration registers (highest_type returns to 15).
module frame_checker_crc16_core
  import fcc16_pkg::*;
#(
  parameter int COUNT_BITS = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] data_byte
  input  logic                   s_tlast,   // last_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [2:0] status, [6:3] version, [10:7] frame_type, [18:11] flag_bits,
  // [26:19] hop_limit, [90:27] source, [154:91] destination,
  // [186:155] sequence_res, [202:187] payload_length, [207:203] zero
  output logic [M_DATA_W-1:0]    m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // The length compare needs room for both the byte count and header plus payload.
  localparam int LEN_W = ((COUNT_BITS > 17) ? COUNT_BITS : 17) + 1;

  // Configuration registers.
  logic [15:0] expected_magic;
  logic [3:0]  expected_version;
  logic [3:0]  highest_type;

  // Frame state.
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [15:0] crc_value, crc_value_next;
  logic [15:0] delay_bytes, delay_bytes_next;
  logic [15:0] magic_seen, magic_seen_next;
  logic [7:0]  version_type, version_type_next;
  logic [7:0]  flags_seen, flags_seen_next;
  logic [7:0]  ttl_seen, ttl_seen_next;
  logic [63:0] source_seen, source_seen_next;
  logic [63:0] destination_seen, destination_seen_next;
  logic [31:0] sequence_seen, sequence_seen_next;
  logic [15:0] length_seen, length_seen_next;

  // Values after this beat's capture, before any end-of-frame clear.
  logic [15:0] cap_magic;
  logic [7:0]  cap_vt;
  logic [7:0]  cap_flags;
  logic [7:0]  cap_ttl;
  logic [63:0] cap_source;
  logic [63:0] cap_dest;
  logic [31:0] cap_seq;
  logic [15:0] cap_length;
  logic [15:0] crc_fed;

  logic            in_acc;
  logic            saturated;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] want_len;
  logic [15:0]     crc_rx;
  logic [2:0]      status;
  logic [M_DATA_W-1:0] result;

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  // Header capture: each header byte lands in its own slot by position.
  always_comb begin
    cap_magic  = magic_seen;
    cap_vt     = version_type;
    cap_flags  = flags_seen;
    cap_ttl    = ttl_seen;
    cap_source = source_seen;
    cap_dest   = destination_seen;
    cap_seq    = sequence_seen;
    cap_length = length_seen;
    if (byte_count == COUNT_BITS'(HDR_MAGIC_LO)) cap_magic[7:0] = s_tdata;
    if (byte_count == COUNT_BITS'(HDR_MAGIC_HI)) cap_magic[15:8] = s_tdata;
    if (byte_count == COUNT_BITS'(HDR_VER_TYPE)) cap_vt = s_tdata;
    if (byte_count == COUNT_BITS'(HDR_FLAGS)) cap_flags = s_tdata;
    if (byte_count == COUNT_BITS'(HDR_TTL)) cap_ttl = s_tdata;
    for (int k = 0; k < 8; k++) begin
      if (byte_count == COUNT_BITS'(HDR_SOURCE + k)) cap_source[8*k +: 8] = s_tdata;
      if (byte_count == COUNT_BITS'(HDR_DEST + k)) cap_dest[8*k +: 8] = s_tdata;
    end
    for (int k = 0; k < 4; k++) begin
      if (byte_count == COUNT_BITS'(HDR_SEQUENCE + k)) cap_seq[8*k +: 8] = s_tdata;
    end
    if (byte_count == COUNT_BITS'(HDR_LENGTH_LO)) cap_length[7:0] = s_tdata;
    if (byte_count == COUNT_BITS'(HDR_LENGTH_HI)) cap_length[15:8] = s_tdata;
  end

  // The CRC runs two bytes behind the input, so the trailing CRC bytes never enter it.
  assign crc_fed   = (byte_count >= COUNT_BITS'(CRC_BYTES))
                     ? crc16_byte(crc_value, delay_bytes[15:8]) : crc_value;
  assign saturated = &byte_count;
  assign frame_len = LEN_W'(byte_count) + LEN_W'(1);
  assign want_len  = LEN_W'(cap_length) + LEN_W'(MIN_FRAME);
  assign crc_rx    = {s_tdata, delay_bytes[7:0]};

  // First failing check wins.
  always_comb begin
    priority if (!saturated && frame_len < LEN_W'(MIN_FRAME)) begin
      status = ST_SHORT;
    end else if (cap_magic != expected_magic) begin
      status = ST_MAGIC;
    end else if (cap_vt[7:4] != expected_version) begin
      status = ST_VERSION;
    end else if (cap_vt[3:0] > highest_type) begin
      status = ST_TYPE;
    end else if (saturated || frame_len != want_len) begin
      status = ST_LENGTH;
    end else if (crc_fed != crc_rx) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  assign result = {{(M_DATA_W - RES_BITS){1'b0}}, cap_length, cap_seq, cap_dest,
                   cap_source, cap_ttl, cap_flags, cap_vt[3:0], cap_vt[7:4], status};

  // Next frame state: advance on a beat, return to the idle values after the final one.
  always_comb begin
    byte_count_next       = byte_count;
    crc_value_next        = crc_value;
    delay_bytes_next      = delay_bytes;
    magic_seen_next       = magic_seen;
    version_type_next     = version_type;
    flags_seen_next       = flags_seen;
    ttl_seen_next         = ttl_seen;
    source_seen_next      = source_seen;
    destination_seen_next = destination_seen;
    sequence_seen_next    = sequence_seen;
    length_seen_next      = length_seen;
    if (in_acc) begin
      if (s_tlast) begin
        byte_count_next       = '0;
        crc_value_next        = CRC_INIT;
        delay_bytes_next      = '0;
        magic_seen_next       = '0;
        version_type_next     = '0;
        flags_seen_next       = '0;
        ttl_seen_next         = '0;
        source_seen_next      = '0;
        destination_seen_next = '0;
        sequence_seen_next    = '0;
        length_seen_next      = '0;
      end else begin
        byte_count_next       = saturated ? byte_count : byte_count + COUNT_BITS'(1);
        crc_value_next        = crc_fed;
        delay_bytes_next      = {delay_bytes[7:0], s_tdata};
        magic_seen_next       = cap_magic;
        version_type_next     = cap_vt;
        flags_seen_next       = cap_flags;
        ttl_seen_next         = cap_ttl;
        source_seen_next      = cap_source;
        destination_seen_next = cap_dest;
        sequence_seen_next    = cap_seq;
        length_seen_next      = cap_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      crc_value        <= CRC_INIT;
      delay_bytes      <= '0;
      magic_seen       <= '0;
      version_type     <= '0;
      flags_seen       <= '0;
      ttl_seen         <= '0;
      source_seen      <= '0;
      destination_seen <= '0;
      sequence_seen    <= '0;
      length_seen      <= '0;
    end else begin
      byte_count       <= byte_count_next;
      crc_value        <= crc_value_next;
      delay_bytes      <= delay_bytes_next;
      magic_seen       <= magic_seen_next;
      version_type     <= version_type_next;
      flags_seen       <= flags_seen_next;
      ttl_seen         <= ttl_seen_next;
      source_seen      <= source_seen_next;
      destination_seen <= destination_seen_next;
      sequence_seen    <= sequence_seen_next;
      length_seen      <= length_seen_next;
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= '0;
      expected_version <= '0;
      highest_type     <= 4'hF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:        expected_magic   <= cfg_data;
        REG_VERSION:      expected_version <= cfg_data[3:0];
        REG_HIGHEST_TYPE: highest_type     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Result register: loaded by a final beat, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tlast) begin
      m_tdata <= result;
    end
  end

endmodule

FILE: src/fcc16_checker.sv
// Port-level assertions for the frame checker, bound to the frame checker core.
module fcc16_checker
  import fcc16_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tlast,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [M_DATA_W-1:0]    m_tdata
);

  // A held result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Input is only refused while a result is waiting and not being taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow the result stage");

  // A new result only follows a final input beat.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result without a final beat");

  // Status is a defined code and the padding is zero.
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd7) && (m_tdata[M_DATA_W-1:RES_BITS] == '0))
    else $error("bad status code or padding");

endmodule

bind frame_checker_crc16_core fcc16_checker u_fcc16_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/tb.sv
// Self-checking testbench for the CRC-16 frame checker core.
module tb;
  import fcc16_pkg::*;

  // The core is built with its default counter width, which no frame here
  // comes close to filling.
  localparam int COUNT_BITS  = 17;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS_SHOWN = 10;

  // How the free header bytes (flags, ttl, addresses, sequence) are filled.
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  // One frame report as it sits in m_tdata, status in the lowest bits.
  typedef struct packed {
    logic [15:0] payload_length;
    logic [31:0] sequence_res;
    logic [63:0] destination;
    logic [63:0] source;
    logic [7:0]  hop_limit;
    logic [7:0]  flag_bits;
    logic [3:0]  frame_type;
    logic [3:0]  version;
    logic [2:0]  status;
  } report_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'h00;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  frame_checker_crc16_core #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be driven, the frame under construction and the reports
  // that the frames already accepted are due to produce, oldest first.
  beat_t      beat_q[$];
  logic [7:0] frame_buf[$];
  report_t    pending_reports[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors = 0;
  int bytes_accepted = 0;
  int status_tally[7];
  int stall_cycles = 0;

  // Our copy of the configuration registers, updated whenever they are written.
  logic [15:0] want_magic   = 16'h0000;
  logic [3:0]  want_version = 4'h0;
  logic [3:0]  max_type     = 4'hF;

  // Predicted frame state: byte counter, running CRC, the two-byte hold-back
  // line (newest byte in the low half) and the captured header fields.
  logic [COUNT_BITS-1:0] p_count = '0;
  logic [15:0]           p_crc   = CRC_INIT;
  logic [15:0]           p_delay = 16'h0000;
  logic [15:0]           p_magic = 16'h0000;
  logic [7:0]            p_vt    = 8'h00;
  logic [7:0]            p_flags = 8'h00;
  logic [7:0]            p_ttl   = 8'h00;
  logic [63:0]           p_src   = '0;
  logic [63:0]           p_dst   = '0;
  logic [31:0]           p_seq   = '0;
  logic [15:0]           p_len   = 16'h0000;

  // CRC-16/CCITT-FALSE, one bit at a time: the feedback is the outgoing CRC bit
  // against the incoming data bit, most significant first.
  function automatic logic [15:0] crc_after_byte(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic string report_text(report_t r);
    return $sformatf("st=%0d ver=%h type=%h flags=%h ttl=%h src=%h dst=%h seq=%h len=%h",
                     r.status, r.version, r.frame_type, r.flag_bits, r.hop_limit,
                     r.source, r.destination, r.sequence_res, r.payload_length);
  endfunction

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= MAX_REPORTS_SHOWN) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  // Advances the predicted state by one accepted byte. On the final byte of a
  // frame the checks are applied in priority order, the report is queued and
  // the frame state goes back to its cleared values.
  function automatic void predict_frame_byte(logic [7:0] b, logic last);
    int          pos;
    int          len;
    logic        saturated;
    logic [15:0] prev;
    report_t     r;
    pos       = int'(p_count);
    saturated = &p_count;
    prev      = p_delay;
    if (pos == HDR_MAGIC_LO) begin
      p_magic[7:0] = b;
    end else if (pos == HDR_MAGIC_HI) begin
      p_magic[15:8] = b;
    end else if (pos == HDR_VER_TYPE) begin
      p_vt = b;
    end else if (pos == HDR_FLAGS) begin
      p_flags = b;
    end else if (pos == HDR_TTL) begin
      p_ttl = b;
    end else if (pos < HDR_DEST) begin
      p_src[(pos - HDR_SOURCE)*8 +: 8] = b;
    end else if (pos < HDR_SEQUENCE) begin
      p_dst[(pos - HDR_DEST)*8 +: 8] = b;
    end else if (pos < HDR_LENGTH_LO) begin
      p_seq[(pos - HDR_SEQUENCE)*8 +: 8] = b;
    end else if (pos == HDR_LENGTH_LO) begin
      p_len[7:0] = b;
    end else if (pos == HDR_LENGTH_HI) begin
      p_len[15:8] = b;
    end
    // The CRC only ever sees a byte once two newer ones have arrived, so the
    // trailing two bytes of the frame never enter it.
    if (pos >= CRC_BYTES) begin
      p_crc = crc_after_byte(p_crc, prev[15:8]);
    end
    p_delay = {prev[7:0], b};
    if (!saturated) begin
      p_count = p_count + 1'b1;
    end
    if (last) begin
      len = pos + 1;
      if (!saturated && len < MIN_FRAME) begin
        r.status = ST_SHORT;
      end else if (p_magic != want_magic) begin
        r.status = ST_MAGIC;
      end else if (p_vt[7:4] != want_version) begin
        r.status = ST_VERSION;
      end else if (p_vt[3:0] > max_type) begin
        r.status = ST_TYPE;
      end else if (saturated || len != HDR_LEN + int'(p_len) + CRC_BYTES) begin
        r.status = ST_LENGTH;
      end else if (p_crc != {b, prev[7:0]}) begin
        r.status = ST_CRC;
      end else begin
        r.status = ST_OK;
      end
      r.version        = p_vt[7:4];
      r.frame_type     = p_vt[3:0];
      r.flag_bits      = p_flags;
      r.hop_limit      = p_ttl;
      r.source         = p_src;
      r.destination    = p_dst;
      r.sequence_res   = p_seq;
      r.payload_length = p_len;
      pending_reports.push_back(r);
      p_count = '0;
      p_crc   = CRC_INIT;
      p_delay = '0;
      p_magic = '0;
      p_vt    = '0;
      p_flags = '0;
      p_ttl   = '0;
      p_src   = '0;
      p_dst   = '0;
      p_seq   = '0;
      p_len   = '0;
    end
  endfunction

  // Frame building: a 27-byte header, an optional payload, then the CRC of
  // everything so far appended low byte first.
  function automatic void make_header(logic [15:0] magic, logic [3:0] ver, logic [3:0] typ,
                                      logic [15:0] len_field, int fill);
    logic [7:0] b;
    frame_buf.delete();
    frame_buf.push_back(magic[7:0]);
    frame_buf.push_back(magic[15:8]);
    frame_buf.push_back({ver, typ});
    for (int j = HDR_FLAGS; j < HDR_LENGTH_LO; j++) begin
      b = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
      frame_buf.push_back(b);
    end
    frame_buf.push_back(len_field[7:0]);
    frame_buf.push_back(len_field[15:8]);
  endfunction

  function automatic void add_payload(int n);
    repeat (n) frame_buf.push_back(8'($urandom));
  endfunction

  function automatic void seal_crc();
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_buf[j]) begin
      c = crc_after_byte(c, frame_buf[j]);
    end
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
  endfunction

  // A correct frame for the current register settings.
  function automatic void good_frame(int plen, int fill);
    make_header(want_magic, want_version, 4'($urandom_range(max_type)), 16'(plen), fill);
    add_payload(plen);
    seal_crc();
  endfunction

  function automatic void send_frame();
    beat_t bt;
    foreach (frame_buf[j]) begin
      bt.data = frame_buf[j];
      bt.last = (j == frame_buf.size() - 1);
      beat_q.push_back(bt);
    end
  endfunction

  // Random traffic: mostly structured frames, some clean and some damaged,
  // plus runts and plain noise.
  function automatic void random_frame();
    int kind;
    int plen;
    int n;
    int bit_pos;
    kind = $urandom_range(99);
    plen = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(4);
    if (kind < 84) begin
      if (kind < 60 || kind >= 78) begin
        good_frame(plen, FILL_RANDOM);
      end else begin
        if (kind < 70) begin
          // Header identity fields wrong in any combination.
          make_header($urandom_range(1) ? want_magic : 16'($urandom),
                      $urandom_range(1) ? want_version : 4'($urandom),
                      4'($urandom), 16'(plen), FILL_RANDOM);
        end else begin
          // Length field that does not match the bytes that follow.
          make_header(want_magic, want_version, 4'($urandom_range(max_type)),
                      $urandom_range(1) ? 16'(plen + $urandom_range(3, 1)) : 16'($urandom),
                      FILL_RANDOM);
        end
        add_payload(plen);
        seal_crc();
      end
      if (kind >= 48 && kind < 60) begin
        n = $urandom_range(frame_buf.size() - 1);
        bit_pos = $urandom_range(7);
        frame_buf[n][bit_pos] = ~frame_buf[n][bit_pos];
      end else if (kind >= 78) begin
        // Truncated or overlong copy of a good frame.
        if ($urandom_range(1)) begin
          repeat ($urandom_range(frame_buf.size() - 1, 1)) void'(frame_buf.pop_back());
        end else begin
          add_payload($urandom_range(3, 1));
        end
      end
    end else begin
      n = (kind < 92) ? $urandom_range(MIN_FRAME - 1, 1) : $urandom_range(64, 1);
      frame_buf.delete();
      add_payload(n);
    end
    send_frame();
  endfunction

  // Writes all three registers, then the unused index, on consecutive cycles.
  // Only the low nibble of the version and type words is meaningful.
  task automatic set_config(input logic [15:0] magic_w, version_w, type_w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAGIC;
    cfg_data  <= magic_w;
    @(posedge clk);
    cfg_index <= REG_VERSION;
    cfg_data  <= version_w;
    @(posedge clk);
    cfg_index <= REG_HIGHEST_TYPE;
    cfg_data  <= type_w;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    want_magic   = magic_w;
    want_version = version_w[3:0];
    max_type     = type_w[3:0];
    @(negedge clk);
  endtask

  // Waits until every queued beat has gone in and every report has come out.
  // Checked on the falling edge, when all of the rising edge's updates have settled.
  task automatic drain();
    @(negedge clk);
    while (beat_q.size() != 0 || s_tvalid || pending_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (3) @(negedge clk);
  endtask

  // Sender: a new beat may be presented once the current one has been taken.
  always @(posedge clk) begin
    beat_t head;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (beat_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        head = beat_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= head.data;
        s_tlast  <= head.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Prediction on every accepted input beat, then comparison of any result beat
  // taken on the same edge against the oldest outstanding report.
  always @(posedge clk) begin
    report_t got;
    report_t want;
    string   diff;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_frame_byte(s_tdata, s_tlast);
        bytes_accepted++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[RES_BITS-1:0];
        if (pending_reports.size() == 0) begin
          note_failure($sformatf("report with no frame outstanding: %s", report_text(got)));
        end else begin
          want = pending_reports.pop_front();
          diff = "";
          if (got.status !== want.status) diff = {diff, " status"};
          if (got.version !== want.version) diff = {diff, " version"};
          if (got.frame_type !== want.frame_type) diff = {diff, " frame_type"};
          if (got.flag_bits !== want.flag_bits) diff = {diff, " flag_bits"};
          if (got.hop_limit !== want.hop_limit) diff = {diff, " hop_limit"};
          if (got.source !== want.source) diff = {diff, " source"};
          if (got.destination !== want.destination) diff = {diff, " destination"};
          if (got.sequence_res !== want.sequence_res) diff = {diff, " sequence_res"};
          if (got.payload_length !== want.payload_length) diff = {diff, " payload_length"};
          if (m_tdata[M_DATA_W-1:RES_BITS] !== '0) diff = {diff, " padding"};
          if (diff != "") begin
            note_failure($sformatf("report mismatch in%s\n  exp %s\n  got %s",
                                   diff, report_text(want), report_text(got)));
          end else begin
            status_tally[want.status]++;
          end
        end
      end
    end
  end

  // Watchdog: too long without a beat moving on either side or a configuration write means a hang.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // First pattern: occasional sender gaps, a receiver that mostly stalls.
    tx_idle_pct = 13;
    rx_idle_pct = 84;

    // Reset register values: magic 0, version 0, every type allowed.
    make_header(16'h0000, 4'h0, 4'hF, 16'h0000, FILL_ONES);
    seal_crc();
    send_frame();
    good_frame(3, FILL_ZERO);
    send_frame();
    drain();

    // Opposite extremes: magic all ones, version 15, only type 0 allowed.
    set_config(16'hFFFF, 16'hFFFF, 16'h0000);
    good_frame(0, FILL_ONES);                      // minimum-length frame
    send_frame();
    good_frame(5, FILL_ZERO);
    send_frame();
    frame_buf.delete();                            // one-byte runt
    add_payload(1);
    send_frame();
    make_header(16'hFFFF, 4'hF, 4'h0, 16'h0000, FILL_RANDOM);
    add_payload(1);                                // one byte short of the minimum
    send_frame();
    make_header(16'h7FFF, 4'hF, 4'h0, 16'h0000, FILL_RANDOM);
    seal_crc();
    send_frame();
    make_header(16'hFFFE, 4'h0, 4'h0, 16'h0000, FILL_RANDOM);
    seal_crc();                                    // magic wins over version
    send_frame();
    make_header(16'hFFFF, 4'h0, 4'h0, 16'h0000, FILL_RANDOM);
    seal_crc();
    send_frame();
    make_header(16'hFFFF, 4'hF, 4'hF, 16'h0000, FILL_RANDOM);
    seal_crc();
    send_frame();
    make_header(16'hFFFF, 4'hF, 4'h0, 16'h0001, FILL_RANDOM);
    seal_crc();
    send_frame();
    make_header(16'hFFFF, 4'hF, 4'h0, 16'hFFFF, FILL_ONES);
    add_payload(2);
    seal_crc();
    send_frame();
    good_frame(3, FILL_RANDOM);                    // damaged received CRC
    frame_buf[frame_buf.size() - 1][7] = ~frame_buf[frame_buf.size() - 1][7];
    send_frame();
    good_frame(3, FILL_RANDOM);                    // damaged payload byte
    frame_buf[HDR_LEN][0] = ~frame_buf[HDR_LEN][0];
    send_frame();
    good_frame(2, FILL_RANDOM);                    // one byte more than stated
    add_payload(1);
    send_frame();
    drain();

    set_config(16'($urandom), 16'($urandom), 16'($urandom_range(14, 1)));
    repeat (3) random_frame();
    drain();

    // Second pattern: the sender mostly idles, the receiver rarely stalls.
    // Upper bits of the nibble registers are junk and must be dropped.
    tx_idle_pct = 84;
    rx_idle_pct = 13;
    set_config(16'h0000, 16'hABC0, 16'h123F);
    repeat (3) random_frame();
    drain();

    // Third pattern: no idling on either side, frames back to back.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(16'($urandom), 16'($urandom), 16'($urandom));
    good_frame(1, FILL_RANDOM);
    send_frame();
    repeat (3) random_frame();
    drain();

    repeat (8) @(negedge clk);
    if (pending_reports.size() != 0) begin
      note_failure($sformatf("%0d reports never arrived", pending_reports.size()));
    end
    $display("Checked frame reports from %0d input bytes under three back-pressure patterns,",
             bytes_accepted);
    $display("  the reset and four written register settings: ok %0d, short %0d, %s",
             status_tally[ST_OK], status_tally[ST_SHORT],
             $sformatf("magic %0d, version %0d, type %0d, length %0d, crc %0d; failures %0d",
                       status_tally[ST_MAGIC], status_tally[ST_VERSION],
                       status_tally[ST_TYPE], status_tally[ST_LENGTH],
                       status_tally[ST_CRC], errors));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/fcc16_pkg.sv
src/frame_checker_crc16_core.sv
src/fcc16_checker.sv
tb/tb.sv
